// File: design/fus_pkg.sv
// Shared types and constants for the first-unique-symbol stream block.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package fus_pkg;

  localparam int SYM_W         = 8;
  localparam int ALPHABET_SIZE = 256;
  localparam int FILL_W        = 9;
  localparam logic [SYM_W-1:0] NONE_CODE = 8'd35;

  // command queue between front and back
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_new;  // first sighting of this symbol
  } cmd_t;

endpackage

`default_nettype wire

// File: design/fus_ifs.sv
// Valid/ready channel interfaces for the symbol input and the result output.
// Depends on fus_pkg for the field widths.
`default_nettype none

interface fus_sym_if;
  logic                      valid;
  logic                      ready;
  logic [fus_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface fus_res_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [fus_pkg::SYM_W-1:0] first_symbol;

  modport source (output valid, output found, output first_symbol, input ready);
  modport sink   (input valid, input found, input first_symbol, output ready);
endinterface

`default_nettype wire

// File: design/fus_front.sv
// Front end: accepts symbols, tracks which values were ever seen, and tags
// each item as first sighting or repeat. Depends on fus_pkg and fus_sym_if.
`default_nettype none

module fus_front (
  input  wire logic    clk,
  input  wire logic    rst,
  fus_sym_if.sink      symbols,
  input  wire logic    cmd_full,
  output fus_pkg::cmd_t cmd,
  output logic         cmd_push
);

  logic [fus_pkg::ALPHABET_SIZE-1:0] seen;

  assign symbols.ready = !cmd_full;
  assign cmd_push      = symbols.valid && !cmd_full;
  assign cmd.symbol    = symbols.symbol;
  assign cmd.is_new    = !seen[symbols.symbol];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (cmd_push) begin
      seen[symbols.symbol] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: design/fus_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on fus_pkg for the command type and depth.
`default_nettype none

module fus_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fus_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output fus_pkg::cmd_t      rd_cmd,
  output logic               not_empty
);

  fus_pkg::cmd_t                   entries [fus_pkg::CMD_DEPTH];
  logic [fus_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [fus_pkg::CMD_PTR_W-1:0]   rd_ptr;
  logic [fus_pkg::CMD_CNT_W-1:0]   count;

  assign full      = (count == fus_pkg::CMD_CNT_W'(fus_pkg::CMD_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/fus_back.sv
// Back end: order queue of first sightings, per-symbol repeat flags, head
// drop loop and result register. Depends on fus_pkg and fus_res_if.
`default_nettype none

module fus_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire fus_pkg::cmd_t cmd,
  output logic               cmd_pop,
  fus_res_if.source          results
);

  localparam logic [2:0] ST_CMD  = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_QRD  = 3'd2;
  localparam logic [2:0] ST_DRD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [fus_pkg::SYM_W-1:0]  order_q  [fus_pkg::ALPHABET_SIZE];
  logic                       dead_mem [fus_pkg::ALPHABET_SIZE];
  logic [fus_pkg::SYM_W-1:0]  q_rd;
  logic                       d_rd;

  logic [fus_pkg::SYM_W-1:0]  head;
  logic [fus_pkg::SYM_W-1:0]  tail;
  logic [fus_pkg::FILL_W-1:0] fill;
  logic [fus_pkg::SYM_W-1:0]  head_sym;

  logic                       res_valid;
  logic                       res_found;
  logic [fus_pkg::SYM_W-1:0]  res_first;
  logic                       res_load;
  logic                       res_found_next;
  logic [fus_pkg::SYM_W-1:0]  res_first_next;

  logic out_free;
  logic any_live;
  logic head_hit;

  assign out_free = !res_valid || results.ready;
  assign any_live = (fill != '0);
  assign head_hit = any_live && (cmd.symbol == head_sym);
  assign cmd_pop  = (state == ST_CMD) && cmd_valid && out_free;

  assign results.valid        = res_valid;
  assign results.found        = res_found;
  assign results.first_symbol = res_first;

  // order queue: push at tail, read the entry behind the head
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_new) begin
      order_q[tail] <= cmd.symbol;
    end
    q_rd <= order_q[head + 1'b1];
  end

  // repeat flag: cleared on first sighting, set on any repeat
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      dead_mem[cmd.symbol] <= !cmd.is_new;
    end
    d_rd <= dead_mem[q_rd];
  end

  always_comb begin
    res_load       = 1'b0;
    res_found_next = any_live;
    res_first_next = any_live ? head_sym : fus_pkg::NONE_CODE;
    state_next     = state;
    unique case (state)
      ST_CMD: begin
        if (cmd_pop) begin
          if (cmd.is_new) begin
            res_load       = 1'b1;
            res_found_next = 1'b1;
            res_first_next = any_live ? head_sym : cmd.symbol;
          end else if (head_hit) begin
            state_next = ST_POP;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_POP: begin
        state_next = (fill == fus_pkg::FILL_W'(1)) ? ST_EMIT : ST_QRD;
      end
      ST_QRD: begin
        state_next = ST_DRD;
      end
      ST_DRD: begin
        state_next = d_rd ? ST_POP : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_CMD;
        end
      end
      default: begin
        state_next = ST_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CMD;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (cmd_pop && cmd.is_new) begin
        tail <= tail + 1'b1;
        fill <= fill + 1'b1;
      end
      if (state == ST_POP) begin
        head <= head + 1'b1;
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_new && !any_live) begin
      head_sym <= cmd.symbol;
    end else if (state == ST_QRD) begin
      head_sym <= q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_found <= res_found_next;
      res_first <= res_first_next;
    end
  end

endmodule

`default_nettype wire

// File: design/first_unique_symbol_stream.sv
// Top level of the first-unique-symbol stream block.
// Depends on fus_pkg, fus_ifs, fus_front, fus_cmd_fifo and fus_back.
`default_nettype none

// One byte goes in per item, one result comes out per item: found and the
// oldest byte value seen exactly once so far, or found low with '#' (35).
// The front end keeps a seen flag per byte value (cleared at reset, no
// clearing pass) and tags each item as first sighting or repeat; a two-entry
// command queue parts it from the back end, which owns the order queue,
// a repeat flag per value and the result register. A first sighting, or a
// repeat that leaves the current head alive, loads the result directly. When
// the head dies, each dropped entry takes three steps (advance, queue read,
// flag read; the entry that empties the queue needs only the advance), and
// an emit step then loads the result once the output is free. These steps
// come from the back end's single-ported lookups. Each byte value enters the
// order queue at most once, so drops average under one per item. The
// result is held in an output register, so the front keeps accepting while
// a result waits, until the command queue fills.
module first_unique_symbol_stream (
  input  wire logic clk,
  input  wire logic rst,
  fus_sym_if.sink   symbols,
  fus_res_if.source results
);

  fus_pkg::cmd_t push_cmd;
  fus_pkg::cmd_t head_cmd;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_valid;

  fus_front u_front (
    .clk      (clk),
    .rst      (rst),
    .symbols  (symbols),
    .cmd_full (cmd_full),
    .cmd      (push_cmd),
    .cmd_push (cmd_push)
  );

  fus_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .wr_cmd    (push_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .rd_cmd    (head_cmd),
    .not_empty (cmd_valid)
  );

  fus_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (head_cmd),
    .cmd_pop   (cmd_pop),
    .results   (results)
  );

endmodule

`default_nettype wire
